// ----- src/d3t_pkg.sv -----
`default_nettype none

package d3t_pkg;

  localparam int NB_BITS    = 26;
  localparam int CUBE_CELLS = 27;
  localparam int NUM_DIRS   = 6;
  localparam int MIN_COUNT  = 4;
  localparam int FULL_COUNT = 8;

  typedef logic [NB_BITS-1:0]    nbhd_t;
  typedef logic [CUBE_CELLS-1:0] cube_t;
  typedef logic [4:0]            cell_idx_t;
  typedef logic [4:0]            count_t;
  typedef logic [2:0]            dir_code_t;

  typedef cell_idx_t [CUBE_CELLS-1:0] cell_map_t;
  typedef cell_map_t [NUM_DIRS-1:0]   dir_map_t;

  // Sweep direction codes: the face that counts as up.
  typedef enum logic [2:0] {
    DIR_POS_Z = 3'd0,
    DIR_NEG_Z = 3'd1,
    DIR_POS_Y = 3'd2,
    DIR_NEG_Y = 3'd3,
    DIR_POS_X = 3'd4,
    DIR_NEG_X = 3'd5
  } dir_t;

  // Neighborhood turned so that up is always +u, together with a flag that
  // says whether the direction code named a face at all.
  typedef struct packed {
    logic  dir_ok;
    cube_t cube;
  } orient_t;

  // Cell number of an offset within the 3x3x3 cube, first axis fastest.
  function automatic int cell_of(int a, int b, int u);
    return (u + 1) * 9 + (b + 1) * 3 + (a + 1);
  endfunction

  // For each direction and each cell of the canonical cube (a, b, u), the
  // cell of the original cube that lands there.
  function automatic dir_map_t build_dir_map();
    dir_map_t m;
    int axis;
    int oa;
    int ob;
    int s;
    int v [3];
    m = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      axis = 2 - (d >> 1);
      s    = ((d & 1) != 0) ? -1 : 1;
      oa   = (axis == 2) ? 0 : axis + 1;
      ob   = (oa == 2) ? 0 : oa + 1;
      for (int du = -1; du <= 1; du++) begin
        for (int db = -1; db <= 1; db++) begin
          for (int da = -1; da <= 1; da++) begin
            v[axis] = s * du;
            v[oa]   = da;
            v[ob]   = db;
            m[d][cell_of(da, db, du)] = cell_idx_t'(cell_of(v[0], v[1], v[2]));
          end
        end
      end
    end
    return m;
  endfunction

  localparam dir_map_t DIR_MAP = build_dir_map();

endpackage

`default_nettype wire

// ----- src/d3t_nbhd_if.sv -----
`default_nettype none

interface d3t_nbhd_if;
  logic               valid;
  logic               ready;
  logic [25:0]        neighborhood;

  modport source (output valid, output neighborhood, input ready);
  modport sink   (input valid, input neighborhood, output ready);
endinterface

`default_nettype wire

// ----- src/d3t_result_if.sv -----
`default_nettype none

interface d3t_result_if;
  logic valid;
  logic ready;
  logic deletable;

  modport source (output valid, output deletable, input ready);
  modport sink   (input valid, input deletable, output ready);
endinterface

`default_nettype wire

// ----- src/d3t_cfg_if.sv -----
`default_nettype none

interface d3t_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] sweep_direction;

  modport source (output valid, output sweep_direction, input ready);
  modport sink   (input valid, input sweep_direction, output ready);
endinterface

`default_nettype wire

// ----- src/d3t_orient.sv -----
`default_nettype none

module d3t_orient (
  input  d3t_pkg::nbhd_t     nbhd,
  input  d3t_pkg::dir_code_t dir,
  output d3t_pkg::orient_t   orient
);
  import d3t_pkg::*;

  cube_t cube_in;

  // The center cell carries no bit; it reads as background.
  assign cube_in = {nbhd[NB_BITS-1:13], 1'b0, nbhd[12:0]};

  always_comb begin
    orient = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (dir == dir_code_t'(d)) begin
        orient.dir_ok = 1'b1;
        for (int c = 0; c < CUBE_CELLS; c++) begin
          orient.cube[c] = cube_in[DIR_MAP[d][c]];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/d3t_eval.sv -----
`default_nettype none

module d3t_eval (
  input  d3t_pkg::orient_t orient,
  output logic             deletable
);
  import d3t_pkg::*;

  function automatic logic vox(cube_t cb, int a, int b, int u);
    return cb[cell_idx_t'(cell_of(a, b, u))];
  endfunction

  always_comb begin
    logic   reject;
    logic   pair_ok;
    count_t cnt;

    cnt    = count_t'($countones(orient.cube));
    reject = !orient.dir_ok || vox(orient.cube, 0, 0, 1) || !vox(orient.cube, 0, 0, -1);

    // Background lateral with object directly above it.
    for (int s = -1; s <= 1; s += 2) begin
      reject = reject || (!vox(orient.cube, s, 0, 0) && vox(orient.cube, s, 0, 1));
      reject = reject || (!vox(orient.cube, 0, s, 0) && vox(orient.cube, 0, s, 1));
    end

    // Background corner pattern with object above its edge voxel; also look
    // for two adjacent object laterals for the mid-range count case.
    pair_ok = 1'b0;
    for (int sa = -1; sa <= 1; sa += 2) begin
      for (int sb = -1; sb <= 1; sb += 2) begin
        reject = reject || (!vox(orient.cube, sa, 0, 0) && !vox(orient.cube, 0, sb, 0) &&
                            !vox(orient.cube, sa, sb, 0) && vox(orient.cube, sa, sb, 1));
        pair_ok = pair_ok || (vox(orient.cube, sa, 0, 0) && vox(orient.cube, 0, sb, 0));
      end
    end

    // Bottom is known to be object here, so the face condition always holds.
    deletable = !reject && ((cnt >= count_t'(FULL_COUNT)) ||
                            ((cnt >= count_t'(MIN_COUNT)) && pair_ok));
  end

endmodule

`default_nettype wire

// ----- src/directional_3d_thinning_deletable_test.sv -----
`default_nettype none

// Deletability test for one sweep of directional 3-D thinning. Each input
// transaction carries the 26-voxel neighborhood of an object voxel (bit k is
// cell z*9+y*3+x of the 3x3x3 cube, the center skipped) and yields exactly one
// result transaction with the deletable flag, in order. The sweep direction
// register (0 +z, 1 -z, 2 +y, 3 -y, 4 +x, 5 -x; codes 6 and 7 never delete)
// is written through the configuration channel, by the user only while no
// transactions are in flight (the block does not enforce this); it resets to
// +z. The block is a two-register pipeline: the neighborhood is captured in an
// input register, the whole test is one short combinational pass, and the flag
// lands in a result register. The result is offered once it has moved from the
// input register into the result register, which a stalled result can hold
// back. One neighborhood is accepted every cycle as long as results are taken;
// a stalled result holds both registers once the input register is also full.
module directional_3d_thinning_deletable_test (
  input  wire logic   clk,
  input  wire logic   rst,
  d3t_nbhd_if.sink    nbhd,
  d3t_result_if.source result,
  d3t_cfg_if.sink     cfg
);
  import d3t_pkg::*;

  dir_code_t direction;

  logic      s1_valid;
  nbhd_t     s1_nbhd;
  logic      s2_valid;
  logic      s2_deletable;

  logic      s2_load;
  logic      s1_load;
  orient_t   orient;
  logic      deletable_next;

  // The configuration channel is always ready; only the low three bits exist.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= dir_code_t'(DIR_POS_Z);
    end else if (cfg.valid) begin
      direction <= cfg.sweep_direction;
    end
  end

  // The result register takes a new value when it is empty or being drained;
  // the input register moves on whenever its contents can advance.
  assign s2_load    = !s2_valid || result.ready;
  assign s1_load    = !s1_valid || s2_load;
  assign nbhd.ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= nbhd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && nbhd.valid) begin
      s1_nbhd <= nbhd.neighborhood;
    end
  end

  // Rotate the neighborhood so that up is always the same face, then run the
  // fixed pattern test on it.
  d3t_orient u_orient (
    .nbhd   (s1_nbhd),
    .dir    (direction),
    .orient (orient)
  );

  d3t_eval u_eval (
    .orient    (orient),
    .deletable (deletable_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_deletable <= deletable_next;
    end
  end

  assign result.valid     = s2_valid;
  assign result.deletable = s2_deletable;

endmodule

`default_nettype wire
